// File: hdl/session_handle_table_assert.svh
// ----------------------------------------------------------------------------
// session handle table assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SESSION_HANDLE_TABLE_ASSERT_SVH
`define SESSION_HANDLE_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define SHT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("session handle table check failed");

// antecedent in one cycle implies consequent in the next
`define SHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("session handle table check failed");

`else

`define SHT_ASSERT(label, clk, rst, prop)
`define SHT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/sht_pkg.sv
// ----------------------------------------------------------------------------
// sht_pkg
// shared widths, operation codes and entry types of the session handle table
// ----------------------------------------------------------------------------
package sht_pkg;

  localparam int SLOT_COUNT_DEFAULT = 16;

  localparam int HANDLE_W    = 32;
  localparam int SALT_W      = 24;
  localparam int CONN_W      = 16;
  localparam int SLOT_BYTE_W = 8;
  localparam int MODE_W      = 2;

  localparam logic [MODE_W-1:0] MODE_REGISTER   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNREGISTER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_VALIDATE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DROP       = 2'd3;

  typedef struct packed {
    logic [SALT_W-1:0] salt;
    logic [CONN_W-1:0] conn;
  } sht_entry_t;

  // what the store reports on the slot read in the previous cycle
  typedef struct packed {
    logic used;
    logic conn_hit;
    logic salt_hit;
  } sht_status_t;

endpackage

// File: hdl/sht_slot_store.sv
// ----------------------------------------------------------------------------
// sht_slot_store
// slot memory with used flags, registered read and key compare
// ----------------------------------------------------------------------------
module sht_slot_store
  import sht_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] rd_addr,
  input  logic                                      wr_en,
  input  logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] wr_addr,
  input  sht_entry_t                                wr_data,
  input  logic                                      clr_en,
  input  logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] clr_addr,
  input  logic [CONN_W-1:0]                         key_conn,
  input  logic [SALT_W-1:0]                         key_salt,
  output sht_status_t                               status
);

  sht_entry_t             mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  used;
  sht_entry_t             rd_entry;
  logic                   rd_used;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_entry <= mem[rd_addr];
  end

  // used flags live in flops so reset empties the table at once
  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      rd_used <= 1'b0;
    end else begin
      rd_used <= used[rd_addr];
      if (wr_en) begin
        used[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        used[clr_addr] <= 1'b0;
      end
    end
  end

  assign status.used     = rd_used;
  assign status.conn_hit = (rd_entry.conn == key_conn);
  assign status.salt_hit = (rd_entry.salt == key_salt);

endmodule

// File: hdl/session_handle_table.sv
// ----------------------------------------------------------------------------
// session_handle_table
// fixed-depth session table addressed by salted one-based slot handles
// ----------------------------------------------------------------------------
//  channel   handshake        word
//  request   start / busy     mode, connection_id, handle, salt
//  result    done (strobe)    ok, handle_out
//
//  register and drop scan the slot memory one slot a cycle through its
//  single read port; register stops early on a free slot.
//  unregister and validate read one slot; a handle naming no slot
//  answers without a slot read.
//  synchronous reset empties the table at once; a new request may be
//  accepted while the last result is on the strobe.
// ----------------------------------------------------------------------------
`include "session_handle_table_assert.svh"

module session_handle_table
  import sht_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [MODE_W-1:0]   mode,
  input  logic [CONN_W-1:0]   connection_id,
  input  logic [HANDLE_W-1:0] handle,
  input  logic [SALT_W-1:0]   salt,
  output logic                done,
  output logic                ok,
  output logic [HANDLE_W-1:0] handle_out
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SLOT_BYTE_W:0] SLOT_LIMIT = (SLOT_BYTE_W + 1)'(SLOT_COUNT);
  localparam logic [SLOT_W-1:0]    SLOT_LAST  = SLOT_W'(SLOT_COUNT - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]          state;
  logic [MODE_W-1:0]   mode_q;
  logic [CONN_W-1:0]   conn_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [SALT_W-1:0]   salt_q;
  logic [SLOT_W-1:0]   idx;
  logic [SLOT_W-1:0]   last;
  logic [SLOT_W-1:0]   rd_idx;
  logic                rd_last;
  logic                rd_live;
  logic                hit_any;
  logic                hit_next;

  sht_status_t         st;
  sht_entry_t          wr_data;

  logic                finish;
  logic                res_ok;
  logic [HANDLE_W-1:0] res_hout;
  logic                alloc;
  logic                free;
  logic                match;

  logic                is_lookup;
  logic                bad_handle;
  logic [SLOT_W-1:0]   lookup_slot;

  assign busy = (state != ST_IDLE);

  assign is_lookup  = (mode == MODE_UNREGISTER) || (mode == MODE_VALIDATE);
  // handle low byte is the one-based slot: zero or beyond the table names none
  assign bad_handle = (handle[SLOT_BYTE_W-1:0] == '0) ||
                      ({1'b0, handle[SLOT_BYTE_W-1:0]} > SLOT_LIMIT);
  assign lookup_slot = SLOT_W'(handle[SLOT_BYTE_W-1:0] - SLOT_BYTE_W'(1));

  assign wr_data.salt = salt_q;
  assign wr_data.conn = conn_q;

  sht_slot_store #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (idx),
    .wr_en    (alloc),
    .wr_addr  (rd_idx),
    .wr_data  (wr_data),
    .clr_en   (free),
    .clr_addr (rd_idx),
    .key_conn (conn_q),
    .key_salt (handle_q[HANDLE_W-1:SLOT_BYTE_W]),
    .status   (st)
  );

  assign match = st.used && st.conn_hit && st.salt_hit;

  // act on the slot read in the previous cycle
  always_comb begin
    finish   = 1'b0;
    res_ok   = 1'b0;
    res_hout = '0;
    alloc    = 1'b0;
    free     = 1'b0;
    hit_next = hit_any;
    if (rd_live) begin
      unique case (mode_q)
        MODE_REGISTER: begin
          if (!st.used) begin
            alloc    = 1'b1;
            finish   = 1'b1;
            res_ok   = 1'b1;
            res_hout = {salt_q, SLOT_BYTE_W'(rd_idx) + SLOT_BYTE_W'(1)};
          end else if (rd_last) begin
            finish = 1'b1;
          end
        end
        MODE_UNREGISTER: begin
          finish = 1'b1;
          res_ok = match;
          free   = match;
        end
        MODE_VALIDATE: begin
          finish = 1'b1;
          res_ok = match;
        end
        MODE_DROP: begin
          if (st.used && st.conn_hit) begin
            free     = 1'b1;
            hit_next = 1'b1;
          end
          if (rd_last) begin
            finish = 1'b1;
            res_ok = hit_next;
          end
        end
        default: begin
          finish = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_idx  <= idx;
    rd_last <= (idx == last);
    if (state == ST_IDLE && start) begin
      mode_q   <= mode;
      conn_q   <= connection_id;
      handle_q <= handle;
      salt_q   <= salt;
      idx      <= is_lookup ? lookup_slot : '0;
      last     <= is_lookup ? lookup_slot : SLOT_LAST;
    end else if (state == ST_READ && idx != last) begin
      idx <= idx + SLOT_W'(1);
    end
    if (finish) begin
      ok         <= res_ok;
      handle_out <= res_hout;
    end else if (state == ST_IDLE && start && is_lookup && bad_handle) begin
      ok         <= 1'b0;
      handle_out <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_live <= 1'b0;
      done    <= 1'b0;
      hit_any <= 1'b0;
    end else begin
      done    <= finish;
      rd_live <= (state == ST_READ) && !finish;
      hit_any <= hit_next;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            hit_any <= 1'b0;
            if (is_lookup && bad_handle) begin
              done <= 1'b1;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          if (finish) begin
            state <= ST_IDLE;
          end else if (idx == last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // an accepted word either starts work or answers on the next strobe
  `SHT_ASSERT_NEXT(a_accept_progress, clk, rst, start && !busy, busy || done)
  // no pending slot read once the sequencer is idle
  `SHT_ASSERT(a_idle_no_read, clk, rst, !busy |-> !rd_live)
  // a handle is only handed out with ok
  `SHT_ASSERT(a_handle_needs_ok, clk, rst, (done && !ok) |-> (handle_out == '0))
  // a granted handle always names a slot
  `SHT_ASSERT(a_grant_slot, clk, rst,
              (done && ok && (handle_out != '0)) |-> (handle_out[SLOT_BYTE_W-1:0] != '0))

endmodule

// File: tb/tb_session_handle_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_session_handle_table
// drives register, unregister, validate and drop requests into the table,
// predicts every reply from a mirror of the slot state and checks each reply
// on the done strobe in order
// ----------------------------------------------------------------------------
module tb_session_handle_table;
  import sht_pkg::*;

  localparam int SLOTS        = SLOT_COUNT_DEFAULT;
  localparam int RANDOM_WORDS = 1100;
  localparam int CYCLE_LIMIT  = 200000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [MODE_W-1:0]   mode = MODE_VALIDATE;
  logic [CONN_W-1:0]   connection_id = '0;
  logic [HANDLE_W-1:0] handle = '0;
  logic [SALT_W-1:0]   salt = '0;
  logic                busy;
  logic                done;
  logic                ok;
  logic [HANDLE_W-1:0] handle_out;

  int unsigned         cycle_count = 0;
  logic [CONN_W-1:0]   conn_pool [4];

  typedef struct {
    logic                ok;
    logic [HANDLE_W-1:0] handle;
  } reply_t;

  class session_table_tracker;
    logic                slot_used [SLOTS];
    logic [SALT_W-1:0]   salt_of [SLOTS];
    logic [CONN_W-1:0]   conn_of [SLOTS];
    reply_t              replies [$];
    int                  mismatches = 0;
    int                  mode_count [4];
    int                  full_refusals = 0;
    int                  ok_count = 0;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      foreach (mode_count[i]) mode_count[i] = 0;
    endfunction

    // accepted request word: update the mirror and queue the reply it earns
    function void note_request(logic [MODE_W-1:0] m, logic [CONN_W-1:0] c,
                               logic [HANDLE_W-1:0] h, logic [SALT_W-1:0] s);
      reply_t                 r;
      int                     idx;
      logic [SLOT_BYTE_W-1:0] low;
      r.ok = 1'b0;
      r.handle = '0;
      idx = -1;
      case (m)
        MODE_REGISTER: begin
          for (int i = 0; i < SLOTS; i++)
            if (!slot_used[i] && idx < 0) idx = i;
          if (idx >= 0) begin
            slot_used[idx] = 1'b1;
            salt_of[idx] = s;
            conn_of[idx] = c;
            low = SLOT_BYTE_W'(idx + 1);
            r.ok = 1'b1;
            r.handle = {s, low};
          end else begin
            full_refusals++;
          end
        end
        MODE_UNREGISTER, MODE_VALIDATE: begin
          low = h[SLOT_BYTE_W-1:0];
          // low byte is a one-based slot number; zero and beyond the table name nothing
          if (low != 0 && low <= SLOTS) begin
            idx = low - 1;
            if (slot_used[idx] && salt_of[idx] == h[HANDLE_W-1:SLOT_BYTE_W] &&
                conn_of[idx] == c) begin
              r.ok = 1'b1;
              if (m == MODE_UNREGISTER) slot_used[idx] = 1'b0;
            end
          end
        end
        default: begin
          for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && conn_of[i] == c) begin
              slot_used[i] = 1'b0;
              r.ok = 1'b1;
            end
        end
      endcase
      mode_count[m]++;
      if (r.ok) ok_count++;
      replies.push_back(r);
    endfunction

    task report_mismatch(string what, logic [HANDLE_W-1:0] want, logic [HANDLE_W-1:0] got);
      if (mismatches < 20)
        $display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, want, got);
      mismatches++;
    endtask

    task check_result(logic got_ok, logic [HANDLE_W-1:0] got_handle);
      reply_t e;
      if (replies.size() == 0) begin
        report_mismatch("reply with no request outstanding", '0, got_handle);
      end else begin
        e = replies.pop_front();
        if (got_ok !== e.ok) report_mismatch("ok", HANDLE_W'(e.ok), HANDLE_W'(got_ok));
        if (got_handle !== e.handle) report_mismatch("handle_out", e.handle, got_handle);
      end
    endtask
  endclass

  session_table_tracker tracker;

  session_handle_table #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .connection_id(connection_id),
    .handle(handle),
    .salt(salt),
    .done(done),
    .ok(ok),
    .handle_out(handle_out)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) tracker.check_result(ok, handle_out);
  end

  // holds start high until the word is taken, then notes it
  task send_request(logic [MODE_W-1:0] m, logic [CONN_W-1:0] c,
                    logic [HANDLE_W-1:0] h, logic [SALT_W-1:0] s);
    @(negedge clk);
    start = 1'b1;
    mode = m;
    connection_id = c;
    handle = h;
    salt = s;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_request(m, c, h, s);
  endtask

  // idle cycles carry junk on the payload, which the block must ignore
  task idle_for(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
      mode = MODE_W'($urandom);
      connection_id = CONN_W'($urandom);
      handle = $urandom;
      salt = SALT_W'($urandom);
    end
  endtask

  function automatic logic [HANDLE_W-1:0] handle_of(int i);
    logic [SLOT_BYTE_W-1:0] low;
    low = SLOT_BYTE_W'(i + 1);
    return {tracker.salt_of[i], low};
  endfunction

  function automatic int pick_live_slot();
    int live [$];
    for (int i = 0; i < SLOTS; i++)
      if (tracker.slot_used[i]) live.push_back(i);
    if (live.size() == 0) return -1;
    return live[$urandom_range(live.size() - 1)];
  endfunction

  function automatic logic [CONN_W-1:0] pool_conn();
    if ($urandom_range(99) < 75) return conn_pool[$urandom_range(3)];
    return CONN_W'($urandom);
  endfunction

  initial begin
    logic [MODE_W-1:0]   m;
    logic [CONN_W-1:0]   c;
    logic [HANDLE_W-1:0] h;
    logic [SALT_W-1:0]   s;
    int                  slot;
    int                  pick;
    int                  idle_pct;

    tracker = new();
    conn_pool[0] = '0;
    conn_pool[1] = '1;
    conn_pool[2] = CONN_W'($urandom);
    conn_pool[3] = CONN_W'($urandom);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill every slot first so that later requests never read an entry that was never written
    for (int i = 0; i < SLOTS; i++) begin
      s = (i == 0) ? '0 : (i == 1) ? '1 : SALT_W'($urandom);
      c = (i < 4) ? '0 : (i < 8) ? '1 : conn_pool[2 + i % 2];
      send_request(MODE_REGISTER, c, $urandom, s);
    end
    send_request(MODE_REGISTER, '1, $urandom, '1);             // table full
    send_request(MODE_VALIDATE, tracker.conn_of[1], handle_of(1), SALT_W'($urandom));
    send_request(MODE_VALIDATE, tracker.conn_of[1] ^ 16'h1, handle_of(1),
                 SALT_W'($urandom));
    send_request(MODE_VALIDATE, '0, '0, SALT_W'($urandom));    // handle zero
    send_request(MODE_VALIDATE, tracker.conn_of[0],
                 {tracker.salt_of[0], SLOT_BYTE_W'(SLOTS + 1)}, SALT_W'($urandom));
    send_request(MODE_UNREGISTER, '1, '1, SALT_W'($urandom));  // slot byte far past the end
    send_request(MODE_UNREGISTER, tracker.conn_of[0], handle_of(0), SALT_W'($urandom));
    send_request(MODE_VALIDATE, tracker.conn_of[0], handle_of(0), SALT_W'($urandom));
    send_request(MODE_DROP, '1, $urandom, SALT_W'($urandom));
    send_request(MODE_DROP, '1, $urandom, SALT_W'($urandom));  // nothing left to drop
    send_request(MODE_REGISTER, pool_conn(), $urandom, SALT_W'($urandom));

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      idle_pct = (k < RANDOM_WORDS / 3) ? 21 : (k < 2 * RANDOM_WORDS / 3) ? 45 : 0;
      pick = $urandom_range(99);
      m = (pick < 30) ? MODE_REGISTER : (pick < 55) ? MODE_UNREGISTER :
          (pick < 85) ? MODE_VALIDATE : MODE_DROP;
      c = pool_conn();
      h = $urandom;
      s = SALT_W'($urandom);
      slot = pick_live_slot();
      if ((m == MODE_UNREGISTER || m == MODE_VALIDATE) && slot >= 0 &&
          $urandom_range(99) < 70) begin
        h = handle_of(slot);
        c = tracker.conn_of[slot];
      end else if (m == MODE_UNREGISTER || m == MODE_VALIDATE) begin
        if (slot >= 0) begin
          h = handle_of(slot);
          c = tracker.conn_of[slot];
        end
        case ($urandom_range(4))
          0: c = c ^ (16'h1 << $urandom_range(CONN_W - 1));
          1: h = h ^ (32'h100 << $urandom_range(SALT_W - 1));
          2: h[SLOT_BYTE_W-1:0] = SLOT_BYTE_W'($urandom_range(255));
          3: h = '0;
          default: h = $urandom;
        endcase
      end else if (m == MODE_DROP && slot >= 0 && $urandom_range(99) < 60) begin
        c = tracker.conn_of[slot];
      end
      send_request(m, c, h, s);
      if ($urandom_range(99) < idle_pct) idle_for($urandom_range(1, 4));
    end

    @(negedge clk);
    start = 1'b0;
    while (tracker.replies.size() != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);

    $display("covered %0d register (%0d refused on a full table), %0d unregister,",
             tracker.mode_count[MODE_REGISTER], tracker.full_refusals,
             tracker.mode_count[MODE_UNREGISTER]);
    $display("%0d validate and %0d drop requests; %0d answered ok",
             tracker.mode_count[MODE_VALIDATE], tracker.mode_count[MODE_DROP],
             tracker.ok_count);
    if (tracker.mismatches == 0 && tracker.replies.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
